// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define KVT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapped implication, checked on every rising clock edge outside reset.
`define KVT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/kvt_pkg.sv =====
package kvt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    // Word that walks the cell row: first as a search pass, then as a commit pass.
    typedef struct packed {
        logic               vld;
        logic               commit;
        logic [1:0]         op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               hit;
        logic [VALUE_W-1:0] found_value;
        logic               free_seen;
        logic               done;
    } kvt_tok_t;

endpackage

// ===== rtl/kvt_cell.sv =====
module kvt_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  kvt_pkg::kvt_tok_t tok_in,
    output kvt_pkg::kvt_tok_t tok_out
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [kvt_pkg::KEY_W-1:0]     key_reg;
    logic [kvt_pkg::KEY_W-1:0]     key_next;
    logic [kvt_pkg::VALUE_W-1:0]   value_reg;
    logic [kvt_pkg::VALUE_W-1:0]   value_next;
    kvt_pkg::kvt_tok_t             tok_reg;
    kvt_pkg::kvt_tok_t             tok_next;
    logic                          match;

    assign match   = valid_reg && (key_reg == tok_in.key);
    assign tok_out = tok_reg;

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (tok_in.vld)
        begin
            if (!tok_in.commit)
            begin
                if (!valid_reg)
                begin
                    tok_next.free_seen = 1'b1;
                end
                unique case (tok_in.op)
                    kvt_pkg::OP_INSERT, kvt_pkg::OP_REMOVE:
                    begin
                        if (match)
                        begin
                            tok_next.hit = 1'b1;
                        end
                    end
                    kvt_pkg::OP_LOOKUP:
                    begin
                        if (match)
                        begin
                            tok_next.hit         = 1'b1;
                            tok_next.found_value = value_reg;
                        end
                    end
                    default:
                    begin
                        tok_next.hit = 1'b0;
                    end
                endcase
            end
            else
            begin
                unique case (tok_in.op)
                    kvt_pkg::OP_INSERT:
                    begin
                        // update in place, or claim the first free entry seen
                        if (tok_in.hit && match)
                        begin
                            value_next = tok_in.value;
                        end
                        else if (!tok_in.hit && !tok_in.done && !valid_reg)
                        begin
                            valid_next    = 1'b1;
                            key_next      = tok_in.key;
                            value_next    = tok_in.value;
                            tok_next.done = 1'b1;
                        end
                    end
                    kvt_pkg::OP_REMOVE:
                    begin
                        if (match)
                        begin
                            valid_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        valid_next = valid_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg   <= key_next;
            value_reg <= value_next;
        end
    end

endmodule

// ===== rtl/key_value_table_core.sv =====
// Associative table of CAPACITY key/value pairs, one operation per request word.
// Request channel (req_valid/req_stall): op, key, value. op 0 inserts or updates,
// op 1 looks up, op 2 removes; op 3 leaves the table alone.
// Response channel (rsp_valid/rsp_stall): hit, found_value, entry_count, overflow,
// exactly one response word per request word, in order.
// Each entry lives in a cell of a row. A request word walks the row once to search
// (match, lookup data, free entry seen) and once more to commit the write. One
// request is in flight at a time: the next is taken once the previous response is
// registered, so the row walk sets the request rate.
// The response register parts the two sides: a new request is taken while an
// earlier response still waits. If a response is ready to leave the row while the
// previous one is still stalled, the whole row holds until the register frees.
// Reset clears every entry, the entry count and both channels; no sweep is needed.
module key_value_table_core
#(
    parameter int CAPACITY = kvt_pkg::CAPACITY_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [1:0]                          op,
    input  logic signed [kvt_pkg::KEY_W-1:0]    key,
    input  logic [kvt_pkg::VALUE_W-1:0]         value,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic                                hit,
    output logic [kvt_pkg::VALUE_W-1:0]         found_value,
    output logic [kvt_pkg::COUNT_W-1:0]         entry_count,
    output logic                                overflow
);

    localparam int NEED_W = $clog2(CAPACITY + 1);
    localparam int CNT_W  = (NEED_W > kvt_pkg::COUNT_W) ? NEED_W : kvt_pkg::COUNT_W;

    kvt_pkg::kvt_tok_t               tok [CAPACITY+1];
    logic [CAPACITY:0]               tok_vld;
    kvt_pkg::kvt_tok_t               exit_tok;
    logic                            adv;
    logic                            req_take;
    logic                            rsp_take;
    logic                            commit_exit;
    logic                            ins_new;

    logic                            busy_reg;
    logic                            busy_next;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    logic                            hit_reg;
    logic                            hit_next;
    logic [kvt_pkg::VALUE_W-1:0]     found_reg;
    logic [kvt_pkg::VALUE_W-1:0]     found_next;
    logic                            ovf_reg;
    logic                            ovf_next;

    assign exit_tok    = tok[CAPACITY];
    assign req_stall   = busy_reg;
    assign req_take    = req_valid && !req_stall;
    assign rsp_take    = rsp_valid_reg && !rsp_stall;
    assign commit_exit = exit_tok.vld && exit_tok.commit;
    assign adv         = !(commit_exit && rsp_valid_reg && rsp_stall);
    assign ins_new     = (exit_tok.op == kvt_pkg::OP_INSERT) && !exit_tok.hit;

    assign rsp_valid   = rsp_valid_reg;
    assign hit         = hit_reg;
    assign found_value = found_reg;
    assign entry_count = count_reg[kvt_pkg::COUNT_W-1:0];
    assign overflow    = ovf_reg;

    // Inject a new request, or turn a finished search around as the commit pass.
    always_comb
    begin
        tok[0] = '0;
        if (req_take)
        begin
            tok[0].vld   = 1'b1;
            tok[0].op    = op;
            tok[0].key   = key;
            tok[0].value = value;
        end
        else if (exit_tok.vld && !exit_tok.commit)
        begin
            tok[0]        = exit_tok;
            tok[0].commit = 1'b1;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        kvt_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    for (genvar j = 0; j <= CAPACITY; j++)
    begin : g_vld
        assign tok_vld[j] = tok[j].vld;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        ovf_next       = ovf_reg;
        if (rsp_take)
        begin
            rsp_valid_next = 1'b0;
        end
        if (req_take)
        begin
            busy_next = 1'b1;
        end
        if (commit_exit && adv)
        begin
            busy_next      = 1'b0;
            rsp_valid_next = 1'b1;
            hit_next       = exit_tok.hit;
            found_next     = exit_tok.found_value;
            ovf_next       = ins_new && !exit_tok.free_seen;
            if (ins_new && exit_tok.done)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if ((exit_tok.op == kvt_pkg::OP_REMOVE) && exit_tok.hit)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        found_reg <= found_next;
        ovf_reg   <= ovf_next;
    end

`include "assert_macros.svh"

    // the row head mirrors the exit word during the turnaround, so count cell outputs only
    `KVT_ASSERT(a_one_word_in_row, $countones(tok_vld[CAPACITY:1]) <= 1, "more than one word in the cell row")
    `KVT_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `KVT_ASSERT_IMP(a_row_needs_busy, tok_vld[CAPACITY:1] != '0, busy_reg, "word in row while idle")
    `KVT_ASSERT_IMP(a_rsp_from_busy, $rose(rsp_valid_reg), $past(busy_reg), "response without request")
    `KVT_ASSERT_IMP(a_ovf_no_hit, rsp_valid_reg, !(ovf_reg && hit_reg), "overflow and hit together")

endmodule

// ===== bench/kvt_table_checker.sv =====
`timescale 1ns / 1ps

module kvt_table_checker
#(
    parameter int CAPACITY = kvt_pkg::CAPACITY_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_stall,
    input  logic [1:0]                          op,
    input  logic signed [kvt_pkg::KEY_W-1:0]    key,
    input  logic [kvt_pkg::VALUE_W-1:0]         value,
    input  logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  logic                                hit,
    input  logic [kvt_pkg::VALUE_W-1:0]         found_value,
    input  logic [kvt_pkg::COUNT_W-1:0]         entry_count,
    input  logic                                overflow,
    output int                                  results_outstanding,
    output int                                  mismatch_count
);

    import kvt_pkg::*;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] found_value;
        logic [COUNT_W-1:0] entry_count;
        logic               overflow;
    } table_result_t;

    logic               slot_used  [CAPACITY];
    logic [KEY_W-1:0]   slot_key   [CAPACITY];
    logic [VALUE_W-1:0] slot_value [CAPACITY];
    int                 used_count;
    table_result_t      pending_results [$];
    int                 errors;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("%0d ns: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Apply one operation to the shadow table and return the word it should produce.
    function automatic table_result_t apply_table_op(input logic [1:0] code,
                                                     input logic [KEY_W-1:0] k,
                                                     input logic [VALUE_W-1:0] v);
        table_result_t r;
        int match_slot;
        int free_slot;
        r = '0;
        match_slot = -1;
        free_slot = -1;
        // scan downward so the lowest index wins
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (slot_used[i] && slot_key[i] == k)
                match_slot = i;
            if (!slot_used[i])
                free_slot = i;
        end
        case (code)
            OP_INSERT:
            begin
                if (match_slot >= 0)
                begin
                    slot_value[match_slot] = v;
                    r.hit = 1'b1;
                end
                else if (free_slot >= 0)
                begin
                    slot_used[free_slot] = 1'b1;
                    slot_key[free_slot] = k;
                    slot_value[free_slot] = v;
                    used_count++;
                end
                else
                    r.overflow = 1'b1;
            end
            OP_LOOKUP:
            begin
                if (match_slot >= 0)
                begin
                    r.hit = 1'b1;
                    r.found_value = slot_value[match_slot];
                end
            end
            OP_REMOVE:
            begin
                if (match_slot >= 0)
                begin
                    slot_used[match_slot] = 1'b0;
                    if (used_count > 0)
                        used_count--;
                    r.hit = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = used_count[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                slot_used[i] = 1'b0;
            used_count = 0;
            errors = 0;
            pending_results.delete();
            results_outstanding <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            // retire the response first: it always belongs to an older word
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("response word with none outstanding", found_value, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", 32'(hit), 32'(want.hit));
                    if (found_value !== want.found_value)
                        report_mismatch("found_value", found_value, want.found_value);
                    if (entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(entry_count),
                                        32'(want.entry_count));
                    if (overflow !== want.overflow)
                        report_mismatch("overflow", 32'(overflow), 32'(want.overflow));
                end
            end
            if (req_valid && !req_stall)
                pending_results.push_back(apply_table_op(op, key, value));
            results_outstanding <= pending_results.size();
            mismatch_count <= errors;
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import kvt_pkg::*;

    localparam int         CAPACITY    = CAPACITY_DEF;
    localparam int         LATENCY     = 2 * CAPACITY + 1;
    localparam int         WORD_TARGET = 2000;
    localparam int         LONG_HOLD   = 300;
    localparam int         IDLE_LIMIT  = 4000;
    localparam int         POOL_SIZE   = 24;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_stall;
    logic [1:0]                 op;
    logic signed [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]         value;
    logic                       rsp_valid;
    logic                       rsp_stall;
    logic                       hit;
    logic [VALUE_W-1:0]         found_value;
    logic [COUNT_W-1:0]         entry_count;
    logic                       overflow;

    int                         results_outstanding;
    int                         mismatch_count;
    int                         words_sent;
    int                         idle_cycles = 0;
    logic                       hold_request;
    logic [KEY_W-1:0]           key_pool [POOL_SIZE];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    key_value_table_core #(.CAPACITY(CAPACITY)) i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .key         (key),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .hit         (hit),
        .found_value (found_value),
        .entry_count (entry_count),
        .overflow    (overflow)
    );

    kvt_table_checker #(.CAPACITY(CAPACITY)) i_checker
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_valid           (req_valid),
        .req_stall           (req_stall),
        .op                  (op),
        .key                 (key),
        .value               (value),
        .rsp_valid           (rsp_valid),
        .rsp_stall           (rsp_stall),
        .hit                 (hit),
        .found_value         (found_value),
        .entry_count         (entry_count),
        .overflow            (overflow),
        .results_outstanding (results_outstanding),
        .mismatch_count      (mismatch_count)
    );

    // Offer one word and return at the edge where it is taken; valid stays up.
    task automatic send_word(input logic [1:0] code, input logic [KEY_W-1:0] k,
                             input logic [VALUE_W-1:0] v);
        req_valid <= 1'b1;
        op <= code;
        key <= k;
        value <= v;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (code != OP_UNUSED)
            words_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
    endtask

    // Mostly reuse a small key set so hits, updates and a full table happen.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 85)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom();
    endfunction

    function automatic logic [1:0] pick_op(input int ins_pct, input int look_pct,
                                           input int rem_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < ins_pct)
            return OP_INSERT;
        if (roll < ins_pct + look_pct)
            return OP_LOOKUP;
        if (roll < ins_pct + look_pct + rem_pct)
            return OP_REMOVE;
        return OP_UNUSED;
    endfunction

    initial
    begin
        int burst_left;
        int gap;
        int phase_words;
        int ins_pct;
        int look_pct;
        int rem_pct;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        op <= OP_INSERT;
        key <= '0;
        value <= '0;
        hold_request <= 1'b0;
        words_sent = 0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: misses
        send_word(OP_LOOKUP, key_pool[2], 32'hFFFF_FFFF);
        send_word(OP_REMOVE, key_pool[3], '0);
        // extreme keys and values
        send_word(OP_INSERT, key_pool[0], 32'hFFFF_FFFF);
        send_word(OP_INSERT, key_pool[1], 32'h0000_0000);
        send_word(OP_INSERT, key_pool[2], 32'h5555_5555);
        send_word(OP_INSERT, key_pool[3], 32'hAAAA_AAAA);
        send_word(OP_INSERT, key_pool[0], 32'h1234_5678);
        send_word(OP_LOOKUP, key_pool[0], '0);
        // free a low slot so the next new key must reuse it
        send_word(OP_REMOVE, key_pool[1], '0);
        for (int i = 4; i < 17; i++)
            send_word(OP_INSERT, key_pool[i], $urandom());
        // table is full now
        send_word(OP_INSERT, key_pool[20], 32'hDEAD_BEEF);
        send_word(OP_INSERT, key_pool[5], 32'h0F0F_0F0F);
        send_word(OP_LOOKUP, key_pool[21], '0);
        send_word(OP_UNUSED, key_pool[5], 32'hFFFF_FFFF);
        send_word(OP_REMOVE, key_pool[2], '0);
        send_word(OP_LOOKUP, key_pool[3], '0);
        wait_drained();

        hold_request <= 1'b1;
        while (words_sent < WORD_TARGET)
        begin
            case ($urandom_range(2))
                0:
                begin
                    ins_pct = 60;
                    look_pct = 25;
                    rem_pct = 12;
                end
                1:
                begin
                    ins_pct = 15;
                    look_pct = 30;
                    rem_pct = 52;
                end
                default:
                begin
                    ins_pct = 34;
                    look_pct = 33;
                    rem_pct = 30;
                end
            endcase
            phase_words = $urandom_range(250, 80);
            while (phase_words > 0 && words_sent < WORD_TARGET)
            begin
                burst_left = $urandom_range(12, 1);
                while (burst_left > 0)
                begin
                    send_word(pick_op(ins_pct, look_pct, rem_pct), pick_key(), $urandom());
                    burst_left--;
                    phase_words--;
                end
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 1);
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            if ($urandom_range(1) == 1)
                wait_drained();
        end

        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Response side: random stall segments, plus one long hold-off to back up the table.
    initial
    begin
        int seg_len;
        int stall_pct;
        bit hold_taken;
        hold_taken = 1'b0;
        rsp_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                case ($urandom_range(2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 40;
                    default: stall_pct = 85;
                endcase
                seg_len = $urandom_range(120, 10);
                repeat (seg_len)
                begin
                    rsp_stall <= ($urandom_range(99) < stall_pct);
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ===== key_value_table_core.f =====
+incdir+rtl
rtl/kvt_pkg.sv
rtl/kvt_cell.sv
rtl/key_value_table_core.sv
bench/kvt_table_checker.sv
bench/testbench.sv
